// ===== rtl/stok_pkg.sv =====
// Shared types and constants for the source tokenizer.
// Holds token kind codes, the token record and the queue entry layout.
// No dependencies.
package stok_pkg;

  localparam logic [2:0] K_INT   = 3'd0;
  localparam logic [2:0] K_FLOAT = 3'd1;
  localparam logic [2:0] K_CHAR  = 3'd2;
  localparam logic [2:0] K_STR   = 3'd3;
  localparam logic [2:0] K_IDENT = 3'd4;
  localparam logic [2:0] K_ERR   = 3'd5;
  localparam logic [2:0] K_END   = 3'd6;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] start_pos;
    logic [15:0] length;
    logic [7:0]  char_value;
  } token_t;

  // One character yields one or two tokens; two marks that tok_b follows tok_a.
  typedef struct packed {
    token_t tok_a;
    token_t tok_b;
    logic   two;
  } entry_t;

endpackage

// ===== rtl/stok_front.sv =====
// Front end of the source tokenizer: accepts characters and runs the scan state.
// Pushes the tokens that each character completes into the queue.
// Depends on stok_pkg.
module stok_front import stok_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] ch,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_NUM,
    M_BADNUM,
    M_CHAR,
    M_STR,
    M_IDENT
  } mode_t;

  localparam logic [7:0] C_NUL    = 8'h00;
  localparam logic [7:0] C_LF     = 8'h0a;
  localparam logic [7:0] C_DQUOTE = 8'h22;
  localparam logic [7:0] C_SQUOTE = 8'h27;
  localparam logic [7:0] C_DOT    = 8'h2e;
  localparam logic [7:0] C_UPF    = 8'h46;
  localparam logic [7:0] C_UNDER  = 8'h5f;
  localparam logic [7:0] C_LOWF   = 8'h66;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic [15:0] len16(input logic [LENGTH_BITS-1:0] v);
    logic [LENGTH_BITS+15:0] ext;
    ext = {16'b0, v};
    return ext[15:0];
  endfunction

  function automatic token_t mk_tok(input logic [2:0] k, input logic [31:0] s,
                                    input logic [15:0] l, input logic [7:0] cv);
    token_t t;
    t.kind       = k;
    t.start_pos  = s;
    t.length     = l;
    t.char_value = cv;
    return t;
  endfunction

  mode_t                  mode, mode_next;
  logic [31:0]            token_start, start_next;
  logic [LENGTH_BITS-1:0] token_length, len_next, len_grow;
  logic [31:0]            position;
  logic [7:0]             first_char, first_char_next;
  logic                   saw_dot, saw_dot_next;

  logic   again;
  logic   t0_v, idle_v;
  token_t t0, idle_t;
  logic   accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign len_grow = (&token_length) ? token_length : token_length + LENGTH_BITS'(1);

  always_comb begin
    mode_next       = mode;
    start_next      = token_start;
    len_next        = token_length;
    first_char_next = first_char;
    saw_dot_next    = saw_dot;
    again           = 1'b0;
    t0_v            = 1'b0;
    t0              = '0;
    idle_v          = 1'b0;
    idle_t          = '0;

    case (mode)
      M_NUM: begin
        if (is_digit(ch)) begin
          len_next = len_grow;
        end else if (ch == C_DOT) begin
          len_next = len_grow;
          if (saw_dot) begin
            mode_next = M_BADNUM;
          end else begin
            saw_dot_next = 1'b1;
          end
        end else if (ch == C_UPF || ch == C_LOWF) begin
          len_next  = len_grow;
          t0_v      = 1'b1;
          t0        = mk_tok(K_FLOAT, token_start, len16(len_grow), 8'h00);
          mode_next = M_IDLE;
        end else begin
          t0_v  = 1'b1;
          t0    = mk_tok(saw_dot ? K_FLOAT : K_INT, token_start, len16(token_length), 8'h00);
          again = 1'b1;
        end
      end
      M_BADNUM: begin
        if (is_digit(ch)) begin
          len_next = len_grow;
        end else begin
          t0_v  = 1'b1;
          t0    = mk_tok(K_ERR, token_start, len16(token_length), 8'h00);
          again = 1'b1;
        end
      end
      M_CHAR: begin
        if (ch == C_LF || ch == C_NUL) begin
          t0_v  = 1'b1;
          t0    = mk_tok(K_ERR, token_start, len16(token_length), 8'h00);
          again = 1'b1;
        end else if (ch == C_SQUOTE) begin
          t0_v = 1'b1;
          if (token_length == '0) begin
            t0         = mk_tok(K_ERR, position, 16'd1, 8'h00);
            start_next = position + 32'd1;
          end else begin
            t0        = mk_tok(K_CHAR, token_start, 16'd1, first_char);
            mode_next = M_IDLE;
          end
        end else begin
          if (token_length == '0) begin
            first_char_next = ch;
          end
          len_next = len_grow;
        end
      end
      M_STR: begin
        if (ch == C_LF || ch == C_NUL) begin
          t0_v  = 1'b1;
          t0    = mk_tok(K_ERR, token_start, len16(token_length), 8'h00);
          again = 1'b1;
        end else if (ch == C_DQUOTE) begin
          t0_v      = 1'b1;
          t0        = mk_tok(K_STR, token_start, len16(token_length), 8'h00);
          mode_next = M_IDLE;
        end else begin
          len_next = len_grow;
        end
      end
      M_IDENT: begin
        if (is_alpha(ch) || is_digit(ch) || ch == C_UNDER) begin
          len_next = len_grow;
        end else begin
          t0_v  = 1'b1;
          t0    = mk_tok(K_IDENT, token_start, len16(token_length), 8'h00);
          again = 1'b1;
        end
      end
      default: begin
        again = 1'b1;
      end
    endcase

    // rescan the character as the start of a new token
    if (again) begin
      mode_next = M_IDLE;
      if (is_space(ch)) begin
        idle_v = 1'b0;
      end else if (ch == C_NUL) begin
        idle_v = 1'b1;
        idle_t = mk_tok(K_END, position, 16'd1, 8'h00);
      end else if (ch == C_SQUOTE || ch == C_DQUOTE) begin
        mode_next  = (ch == C_SQUOTE) ? M_CHAR : M_STR;
        start_next = position + 32'd1;
        len_next   = '0;
      end else if (is_digit(ch)) begin
        mode_next    = M_NUM;
        saw_dot_next = 1'b0;
        start_next   = position;
        len_next     = LENGTH_BITS'(1);
      end else if (is_alpha(ch) || ch == C_UNDER) begin
        mode_next  = M_IDENT;
        start_next = position;
        len_next   = LENGTH_BITS'(1);
      end else begin
        idle_v = 1'b1;
        idle_t = mk_tok(K_ERR, position, 16'd1, 8'h00);
      end
    end
  end

  assign push             = accept && (t0_v || idle_v);
  assign push_entry.tok_a = t0_v ? t0 : idle_t;
  assign push_entry.tok_b = idle_t;
  assign push_entry.two   = t0_v && idle_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      token_start  <= '0;
      token_length <= '0;
      position     <= '0;
      first_char   <= '0;
      saw_dot      <= 1'b0;
    end else if (accept) begin
      mode         <= mode_next;
      token_start  <= start_next;
      token_length <= len_next;
      position     <= position + 32'd1;
      first_char   <= first_char_next;
      saw_dot      <= saw_dot_next;
    end
  end

endmodule

// ===== rtl/stok_fifo.sv =====
// Short queue between the tokenizer front end and the output stage.
// Holds up to QDEPTH entries of one or two tokens each.
// Depends on stok_pkg.
module stok_fifo import stok_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output entry_t q_entry
);

  entry_t              q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push, do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_entry = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/stok_back.sv =====
// Output stage of the source tokenizer: pops queue entries and sends tokens
// one per transfer, holding the second token of a pair. Depends on stok_pkg.
module stok_back import stok_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      q_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] start_pos,
  output logic [15:0] length,
  output logic [7:0]  char_value,
  output logic        last
);

  logic   slot_free;
  logic   sec_pend;
  token_t sec_tok;

  assign slot_free = !out_valid || out_ready;
  assign pop       = slot_free && !sec_pend && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sec_pend  <= 1'b0;
    end else if (slot_free) begin
      if (sec_pend) begin
        out_valid <= 1'b1;
        sec_pend  <= 1'b0;
      end else if (q_valid) begin
        out_valid <= 1'b1;
        sec_pend  <= q_entry.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (sec_pend) begin
        kind       <= sec_tok.kind;
        start_pos  <= sec_tok.start_pos;
        length     <= sec_tok.length;
        char_value <= sec_tok.char_value;
        last       <= 1'b1;
      end else if (q_valid) begin
        kind       <= q_entry.tok_a.kind;
        start_pos  <= q_entry.tok_a.start_pos;
        length     <= q_entry.tok_a.length;
        char_value <= q_entry.tok_a.char_value;
        last       <= !q_entry.two;
        sec_tok    <= q_entry.tok_b;
      end
    end
  end

endmodule

// ===== rtl/source_tokenizer.sv =====
// Source tokenizer, top level: one ASCII character in per transfer, tokens out.
// Instantiates stok_front, stok_fifo and stok_back; depends on stok_pkg.
//
// Input channel: ch with in_valid/in_ready; 0 marks end of input.
// Output channel: kind, start_pos, length, char_value, last with
// out_valid/out_ready. A character yields zero, one or two tokens; last
// marks the final token caused by that character.
// Throughput: one character per cycle while the queue has room. The output
// side moves one token per cycle while out_ready is high, so characters that
// close one token and also yield a one-character token need two output
// transfers; the four-entry queue absorbs such bursts.
// Path: a token is written into the queue and then registered in stok_back
// before it appears on the outputs.
// Reset: scan mode goes idle, position and token state clear, queue empties, out_valid clears.
// Receiver stall: output holds, the queue fills, then in_ready drops until
// the receiver takes tokens again. Scan state is updated only on transfers.
module source_tokenizer import stok_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  ch,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [2:0]  kind,
  output logic [31:0] start_pos,
  output logic [15:0] length,
  output logic [7:0]  char_value,
  output logic        last,
  output logic        out_valid,
  input  logic        out_ready
);

  logic   push, q_full, pop, q_valid;
  entry_t push_entry, q_entry;

  stok_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .ch         (ch),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  stok_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  stok_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .start_pos  (start_pos),
    .length     (length),
    .char_value (char_value),
    .last       (last)
  );

`ifndef SYNTHESIS
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> (out_valid && last))
    else $error("second token of a pair not presented next");

  a_end_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == K_END) |-> (length == 16'd1 && last))
    else $error("end token with bad length or not last");

  a_char_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != K_CHAR) |-> (char_value == 8'h00))
    else $error("char_value set on a non-literal token");
`endif

endmodule

// ===== sim/source_tokenizer_tb.sv =====
// Testbench for source_tokenizer: feeds character streams and checks every token.
// Predicts tokens with its own scanner model and compares them in order.
// Depends on stok_pkg and the source_tokenizer RTL.
module source_tokenizer_tb;
  import stok_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_CHARS = 1100;
  localparam int LONG_HOLD = 300;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_AT         = 8'h40;
  localparam logic [7:0] CH_UPPER_F    = 8'h46;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_F    = 8'h66;
  localparam logic [15:0] LEN_SAT      = 16'hFFFF;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_NUM, SCAN_BADNUM, SCAN_CHAR, SCAN_STR, SCAN_IDENT
  } scan_e;

  typedef struct {
    token_t tok;
    logic   last;
  } emitted_t;

  logic        clk;
  logic        rst;
  logic [7:0]  ch;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  kind;
  logic [31:0] start_pos;
  logic [15:0] length;
  logic [7:0]  char_value;
  logic        last;
  logic        out_valid;
  logic        out_ready;

  scan_e       sc_mode;
  logic [31:0] sc_start;
  logic [15:0] sc_len;
  logic [31:0] sc_pos;
  logic [7:0]  sc_first;
  logic        sc_dot;

  emitted_t tokens_due[$];
  int       errors;
  int       cycle_count;
  int       chars_sent;
  int       burst_left;
  bit       fast_send;
  int       hold_requests;
  int       holds_served;
  int       hold_left;
  int       rx_mode;
  int       rx_phase_left;

  source_tokenizer uut (
    .clk        (clk),
    .rst        (rst),
    .ch         (ch),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .start_pos  (start_pos),
    .length     (length),
    .char_value (char_value),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic token_t make_token(input logic [2:0] k, input logic [31:0] s,
                                        input logic [15:0] l, input logic [7:0] v);
    token_t t;
    t.kind = k;
    t.start_pos = s;
    t.length = l;
    t.char_value = v;
    return t;
  endfunction

  function automatic void grow_token();
    if (sc_len != LEN_SAT) sc_len = sc_len + 16'd1;
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    token_t      found[$];
    emitted_t    e;
    logic [31:0] here;
    bit          rescan;
    here = sc_pos;
    rescan = 1'b0;
    case (sc_mode)
      SCAN_NUM: begin
        if (is_digit(c)) begin
          grow_token();
        end else if (c == CH_DOT) begin
          grow_token();
          if (sc_dot) sc_mode = SCAN_BADNUM;
          else sc_dot = 1'b1;
        end else if (c == CH_UPPER_F || c == CH_LOWER_F) begin
          grow_token();
          found.push_back(make_token(K_FLOAT, sc_start, sc_len, 8'd0));
          sc_mode = SCAN_IDLE;
        end else begin
          found.push_back(make_token(sc_dot ? K_FLOAT : K_INT, sc_start, sc_len, 8'd0));
          rescan = 1'b1;
        end
      end
      SCAN_BADNUM: begin
        if (is_digit(c)) begin
          grow_token();
        end else begin
          found.push_back(make_token(K_ERR, sc_start, sc_len, 8'd0));
          rescan = 1'b1;
        end
      end
      SCAN_CHAR: begin
        if (c == CH_LF || c == CH_NUL) begin
          found.push_back(make_token(K_ERR, sc_start, sc_len, 8'd0));
          rescan = 1'b1;
        end else if (c == CH_QUOTE) begin
          if (sc_len == 16'd0) begin
            found.push_back(make_token(K_ERR, here, 16'd1, 8'd0));
            sc_start = here + 32'd1;
          end else begin
            found.push_back(make_token(K_CHAR, sc_start, 16'd1, sc_first));
            sc_mode = SCAN_IDLE;
          end
        end else begin
          if (sc_len == 16'd0) sc_first = c;
          grow_token();
        end
      end
      SCAN_STR: begin
        if (c == CH_LF || c == CH_NUL) begin
          found.push_back(make_token(K_ERR, sc_start, sc_len, 8'd0));
          rescan = 1'b1;
        end else if (c == CH_DQUOTE) begin
          found.push_back(make_token(K_STR, sc_start, sc_len, 8'd0));
          sc_mode = SCAN_IDLE;
        end else begin
          grow_token();
        end
      end
      SCAN_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE) begin
          grow_token();
        end else begin
          found.push_back(make_token(K_IDENT, sc_start, sc_len, 8'd0));
          rescan = 1'b1;
        end
      end
      default: rescan = 1'b1;
    endcase
    if (rescan) begin
      sc_mode = SCAN_IDLE;
      if (!is_space(c)) begin
        if (c == CH_NUL) begin
          found.push_back(make_token(K_END, here, 16'd1, 8'd0));
        end else if (c == CH_QUOTE || c == CH_DQUOTE) begin
          sc_mode = (c == CH_QUOTE) ? SCAN_CHAR : SCAN_STR;
          sc_start = here + 32'd1;
          sc_len = 16'd0;
        end else if (is_digit(c)) begin
          sc_mode = SCAN_NUM;
          sc_dot = 1'b0;
          sc_start = here;
          sc_len = 16'd1;
        end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
          sc_mode = SCAN_IDENT;
          sc_start = here;
          sc_len = 16'd1;
        end else begin
          found.push_back(make_token(K_ERR, here, 16'd1, 8'd0));
        end
      end
    end
    foreach (found[i]) begin
      e.tok = found[i];
      e.last = (i == found.size() - 1);
      tokens_due.push_back(e);
    end
    sc_pos = here + 32'd1;
  endfunction

  task automatic send_char(input logic [7:0] c);
    int gap;
    if (!fast_send && burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    ch <= c;
    do @(posedge clk); while (!in_ready);
    scan_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_word_char(input bit lead);
    int sel;
    sel = $urandom_range(lead ? 1 : 0, 3);
    case (sel)
      0: return rand_digit();
      1: return CH_UNDERSCORE;
      2: return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_body_char(input logic [7:0] closer);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_LF || c == closer);
    return c;
  endfunction

  function automatic logic [7:0] rand_stray_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (is_digit(c) || is_alpha(c) || is_space(c) || c == CH_UNDERSCORE ||
           c == CH_QUOTE || c == CH_DQUOTE);
    return c;
  endfunction

  function automatic logic [7:0] rand_space();
    int w;
    w = $urandom_range(8, 13);
    return (w == 8) ? CH_SPACE : 8'(w);
  endfunction

  task automatic send_random_token();
    logic [7:0] seq[$];
    logic [7:0] q;
    int sel;
    int n;
    sel = $urandom_range(0, 15);
    case (sel)
      0, 1: begin
        n = $urandom_range(1, 5);
        repeat (n) seq.push_back(rand_digit());
      end
      2: begin
        repeat ($urandom_range(1, 3)) seq.push_back(rand_digit());
        seq.push_back(CH_DOT);
        repeat ($urandom_range(0, 3)) seq.push_back(rand_digit());
      end
      3: begin
        repeat ($urandom_range(1, 3)) seq.push_back(rand_digit());
        if ($urandom_range(0, 1)) begin
          seq.push_back(CH_DOT);
          repeat ($urandom_range(0, 2)) seq.push_back(rand_digit());
        end
        seq.push_back($urandom_range(0, 1) ? CH_UPPER_F : CH_LOWER_F);
      end
      4: begin
        repeat ($urandom_range(1, 2)) seq.push_back(rand_digit());
        seq.push_back(CH_DOT);
        repeat ($urandom_range(0, 2)) seq.push_back(rand_digit());
        seq.push_back(CH_DOT);
        repeat ($urandom_range(0, 3)) seq.push_back(rand_digit());
        if ($urandom_range(0, 2) == 0) seq.push_back(CH_DOT);
      end
      5: begin
        seq.push_back(CH_QUOTE);
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
        repeat (n) seq.push_back(rand_body_char(CH_QUOTE));
        seq.push_back(CH_QUOTE);
      end
      6: begin
        seq.push_back(CH_DQUOTE);
        repeat ($urandom_range(0, 8)) seq.push_back(rand_body_char(CH_DQUOTE));
        seq.push_back(CH_DQUOTE);
      end
      7, 8: begin
        seq.push_back(rand_word_char(1'b1));
        repeat ($urandom_range(0, 6)) seq.push_back(rand_word_char(1'b0));
      end
      9: begin
        q = $urandom_range(0, 1) ? CH_QUOTE : CH_DQUOTE;
        seq.push_back(q);
        repeat ($urandom_range(0, 4)) seq.push_back(rand_body_char(q));
        seq.push_back($urandom_range(0, 1) ? CH_LF : CH_NUL);
      end
      10: seq.push_back(CH_NUL);
      11: seq.push_back(rand_stray_char());
      12: repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom_range(0, 255)));
      default: seq.push_back(rand_space());
    endcase
    if ($urandom_range(0, 1)) seq.push_back(rand_space());
    foreach (seq[i]) send_char(seq[i]);
  endtask

  task automatic test_numbers();
    send_text("9.1.2 0f5.x ");
  endtask

  task automatic test_literals();
    send_text("''a'\"s\"'\n\"");
    send_char(CH_NUL);
  endtask

  task automatic test_stray_chars();
    send_text("_@");
    send_char(8'h80);
    send_char(8'hFF);
    for (int w = 9; w <= 13; w++) send_char(8'(w));
  endtask

  task automatic test_backpressure();
    fast_send = 1'b1;
    hold_requests++;
    repeat (16) begin
      send_char(CH_LOWER_A);
      send_char(CH_AT);
    end
    fast_send = 1'b0;
  endtask

  task automatic test_random_stream();
    int goal;
    goal = chars_sent + RANDOM_CHARS;
    while (chars_sent < goal) send_random_token();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      holds_served <= holds_served + 1;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_phase_left <= $urandom_range(20, 200);
      end else begin
        rx_phase_left <= rx_phase_left - 1;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  always @(posedge clk) begin
    emitted_t e;
    if (!rst && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: unexpected token kind=%0d start=%0d len=%0d char=%0d last=%0d",
                 $time, kind, start_pos, length, char_value, last);
        errors++;
      end else begin
        e = tokens_due.pop_front();
        if (kind !== e.tok.kind || start_pos !== e.tok.start_pos ||
            length !== e.tok.length || char_value !== e.tok.char_value ||
            last !== e.last) begin
          $display("%0t: expected kind=%0d start=%0d len=%0d char=%0d last=%0d", $time,
                   e.tok.kind, e.tok.start_pos, e.tok.length, e.tok.char_value, e.last);
          $display("%0t:   actual kind=%0d start=%0d len=%0d char=%0d last=%0d", $time,
                   kind, start_pos, length, char_value, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    ch = 8'd0;
    out_ready = 1'b0;
    errors = 0;
    cycle_count = 0;
    chars_sent = 0;
    burst_left = 0;
    fast_send = 1'b0;
    hold_requests = 0;
    holds_served = 0;
    hold_left = 0;
    rx_mode = 0;
    rx_phase_left = 0;
    sc_mode = SCAN_IDLE;
    sc_start = '0;
    sc_len = '0;
    sc_pos = '0;
    sc_first = '0;
    sc_dot = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_numbers();
    test_literals();
    test_stray_chars();
    test_backpressure();
    test_random_stream();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
